### sv/bcc_pkg.sv
package bcc_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(50);
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = CFG_W'(500);
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(1000);

  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DOUBLE_CLICK = 2'd1,
    REG_LONG_PRESS = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] double_click_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic single_click;
    logic double_click;
    logic long_press;
    logic pressed_level;
  } result_t;

  function automatic time_t elapsed(time_t now, time_t then);
    return now - then;
  endfunction

  function automatic time_t widen(logic [CFG_W-1:0] value);
    return TIME_W'(value);
  endfunction

endpackage

### sv/bcc_regs.sv
module bcc_regs
  import bcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= DEBOUNCE_RESET;
      cfg.double_click_ms <= DOUBLE_CLICK_RESET;
      cfg.long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DEBOUNCE: cfg.debounce_ms <= cfg_data;
        REG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data;
        REG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/bcc_core.sv
module bcc_core
  import bcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    pin_level,
  input  time_t   now_ms,
  input  cfg_t    cfg,
  output result_t res
);

  logic  raw_previous;
  logic  stable_pressed;
  time_t change_time;
  time_t press_start;
  time_t release_time;
  logic  release_pending;

  logic  stable_pressed_next;
  time_t change_time_next;
  time_t press_start_next;
  time_t release_time_next;
  logic  release_pending_next;

  logic  reading;
  logic  take_change;

  always_comb begin
    reading = ~pin_level;
    change_time_next = (reading != raw_previous) ? now_ms : change_time;
    take_change = (elapsed(now_ms, change_time_next) > widen(cfg.debounce_ms)) &&
                  (reading != stable_pressed);

    stable_pressed_next = stable_pressed;
    press_start_next = press_start;
    release_time_next = release_time;
    release_pending_next = release_pending;
    res = '0;

    if (take_change) begin
      stable_pressed_next = reading;
      if (reading) begin
        press_start_next = now_ms;
      end else if (elapsed(now_ms, press_start) >= widen(cfg.long_press_ms)) begin
        res.long_press = 1'b1;
      end else if (release_pending &&
                   elapsed(now_ms, release_time) <= widen(cfg.double_click_ms)) begin
        res.double_click = 1'b1;
        release_pending_next = 1'b0;
      end else begin
        release_time_next = now_ms;
        release_pending_next = 1'b1;
      end
    end

    if (!stable_pressed_next && release_pending_next &&
        elapsed(now_ms, release_time_next) > widen(cfg.double_click_ms)) begin
      res.single_click = 1'b1;
      release_pending_next = 1'b0;
    end

    res.pressed_level = stable_pressed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous <= 1'b0;
      stable_pressed <= 1'b0;
      change_time <= '0;
      release_time <= '0;
      release_pending <= 1'b0;
    end else if (step) begin
      raw_previous <= reading;
      stable_pressed <= stable_pressed_next;
      change_time <= change_time_next;
      release_time <= release_time_next;
      release_pending <= release_pending_next;
    end
  end

  // The press start time is always written by a press before a release reads it.
  always_ff @(posedge clk) begin
    if (step) begin
      press_start <= press_start_next;
    end
  end

endmodule

### sv/button_click_classifier.sv
// A beat taken into the input register moves through the core into the result register when that register can advance.
// Throughput: one beat per cycle while out_stall is low; the debounce and click state update as a beat moves on.
// While the result register is stalled, an empty input register still takes one beat,
// and after that in_stall holds the sender until the result beat is taken.
// Reset (rst, synchronous, active high) clears both valid flags and the button state,
// and loads the reset values 50, 500 and 1000 into the three timing registers.
module button_click_classifier
  import bcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 pin_level,
  input  logic [TIME_W-1:0]    now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 single_click,
  output logic                 double_click,
  output logic                 long_press,
  output logic                 pressed_level
);

  cfg_t    cfg;
  result_t res;
  result_t out_res;

  logic  hold_valid;
  logic  hold_pin;
  time_t hold_now;
  logic  advance;
  logic  step;

  assign advance = !out_valid || !out_stall;
  assign step = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  bcc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pin_level (hold_pin),
    .now_ms    (hold_now),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_pin <= pin_level;
      hold_now <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign single_click = out_res.single_click;
  assign double_click = out_res.double_click;
  assign long_press = out_res.long_press;
  assign pressed_level = out_res.pressed_level;

endmodule

### sv/bcc_checker.sv
module bcc_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic single_click,
  input logic double_click,
  input logic long_press,
  input logic pressed_level
);

  // A release ends in at most one of long press and double click.
  a_release_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(long_press && double_click))
    else $error("long press and double click in the same beat");

  // A double click consumes the pending release, so no single click can expire with it.
  a_no_single_with_double: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(single_click && double_click))
    else $error("single and double click in the same beat");

  // Every click flag comes with the button up.
  a_flags_when_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (single_click || double_click || long_press)) |-> !pressed_level)
    else $error("click reported while the button is pressed");

  a_stalled_beat_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(single_click) &&
      $stable(double_click) && $stable(long_press) && $stable(pressed_level)))
    else $error("stalled result beat changed");

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .single_click  (single_click),
  .double_click  (double_click),
  .long_press    (long_press),
  .pressed_level (pressed_level)
);

### test/button_click_classifier_tb.sv
module button_click_classifier_tb;
  import bcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic  pin;
    time_t at;
  } sample_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic pin_level = 1'b1;
  logic [TIME_W-1:0] now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic single_click;
  logic double_click;
  logic long_press;
  logic pressed_level;

  button_click_classifier u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pin_level(pin_level),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .single_click(single_click),
    .double_click(double_click),
    .long_press(long_press),
    .pressed_level(pressed_level)
  );

  // Click classifier state as the block should hold it.
  logic [CFG_W-1:0] debounce_cfg = DEBOUNCE_RESET;
  logic [CFG_W-1:0] window_cfg = DOUBLE_CLICK_RESET;
  logic [CFG_W-1:0] long_cfg = LONG_PRESS_RESET;
  logic raw_down = 1'b0;
  logic held = 1'b0;
  time_t change_at = '0;
  time_t press_at = '0;
  time_t release_at = '0;
  logic release_waiting = 1'b0;

  sample_t sample_q[$];
  result_t click_q[$];
  sample_t drive_beat;
  result_t oldest_click;
  result_t seen_click;
  time_t t_now = '0;
  int idle_pct = 38;
  int unsigned queued_count = 0;
  int unsigned checked_count = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  function automatic result_t classify_sample(logic pin, time_t now);
    logic down;
    result_t r;
    down = ~pin;
    r = '0;
    if (down != raw_down) change_at = now;
    if (time_t'(now - change_at) > time_t'(debounce_cfg) && down != held) begin
      held = down;
      if (held) begin
        press_at = now;
      end else if (time_t'(now - press_at) >= time_t'(long_cfg)) begin
        r.long_press = 1'b1;
      end else if (release_waiting && time_t'(now - release_at) <= time_t'(window_cfg)) begin
        r.double_click = 1'b1;
        release_waiting = 1'b0;
      end else begin
        release_at = now;
        release_waiting = 1'b1;
      end
    end
    if (!held && release_waiting && time_t'(now - release_at) > time_t'(window_cfg)) begin
      r.single_click = 1'b1;
      release_waiting = 1'b0;
    end
    raw_down = down;
    r.pressed_level = held;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) click_q.push_back(classify_sample(pin_level, now_ms));
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drive_beat = sample_q.pop_front();
          in_valid <= 1'b1;
          pin_level <= drive_beat.pin;
          now_ms <= drive_beat.at;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_click = {single_click, double_click, long_press, pressed_level};
        if (click_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result beat: single=%b double=%b long=%b pressed=%b",
                     single_click, double_click, long_press, pressed_level);
        end else begin
          oldest_click = click_q.pop_front();
          checked_count++;
          if (seen_click !== oldest_click) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"mismatch: expected single=%b double=%b long=%b pressed=%b, ",
                        "got single=%b double=%b long=%b pressed=%b"},
                       oldest_click.single_click, oldest_click.double_click,
                       oldest_click.long_press, oldest_click.pressed_level,
                       single_click, double_click, long_press, pressed_level);
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic add_sample(logic pin, time_t at);
    sample_t s;
    s.pin = pin;
    s.at = at;
    t_now = at;
    sample_q.push_back(s);
    queued_count++;
  endtask

  task automatic add_bounce(logic level);
    int unsigned n;
    n = $urandom_range(0, 3);
    for (int i = n; i > 0; i--)
      add_sample((i % 2) ? ~level : level, t_now + $urandom_range(0, debounce_cfg));
  endtask

  task automatic add_steady(logic level, int unsigned span);
    int unsigned n;
    int unsigned remaining;
    int unsigned dt;
    n = $urandom_range(1, 4);
    remaining = span;
    add_sample(level, t_now + $urandom_range(0, debounce_cfg));
    for (int i = 0; i < n; i++) begin
      dt = (i == n - 1) ? remaining : $urandom_range(0, remaining);
      remaining -= dt;
      add_sample(level, t_now + dt);
    end
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned stop;
    stop = queued_count + count;
    while (queued_count < stop) begin
      if ($urandom_range(99) < 85) begin
        add_bounce(1'b0);
        add_steady(1'b0, debounce_cfg + 1 + $urandom_range(0, 2 * long_cfg + 2));
        add_bounce(1'b1);
        add_steady(1'b1, debounce_cfg + 1 + $urandom_range(0, 2 * window_cfg + 2));
      end else if ($urandom_range(3) == 0) begin
        add_sample(1'($urandom_range(1)), $urandom);
      end else begin
        add_sample(1'($urandom_range(1)), t_now + $urandom_range(0, 2 * debounce_cfg + 2));
      end
    end
  endtask

  task automatic drain();
    while (checked_count < queued_count) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] win,
                            logic [CFG_W-1:0] lng);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk);
    cfg_index <= REG_DOUBLE_CLICK;
    cfg_data <= win;
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_data <= lng;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_cfg = deb;
    window_cfg = win;
    long_cfg = lng;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // A first release near time zero must not be taken for a double click.
    add_sample(1'b1, 0);
    add_sample(1'b0, 10);
    add_sample(1'b0, 61);
    add_sample(1'b1, 100);
    add_sample(1'b1, 151);
    add_sample(1'b0, 200);
    add_sample(1'b0, 251);
    add_sample(1'b1, 300);
    add_sample(1'b1, 351);
    // Long press, ending exactly at the long-press time.
    add_sample(1'b0, 2000);
    add_sample(1'b0, 2051);
    add_sample(1'b1, 3000);
    add_sample(1'b1, 3051);
    // The window expires while the button is held, then the single click
    // fires one millisecond past the window edge.
    add_sample(1'b0, 4000);
    add_sample(1'b0, 4051);
    add_sample(1'b1, 4100);
    add_sample(1'b1, 4151);
    add_sample(1'b0, 4200);
    add_sample(1'b0, 4251);
    add_sample(1'b0, 4800);
    add_sample(1'b1, 5000);
    add_sample(1'b1, 5051);
    add_sample(1'b1, 5551);
    add_sample(1'b1, 5552);
    random_phase(130);
    drain();

    set_config('0, '0, '0);
    add_sample(1'b0, t_now + 1);
    add_sample(1'b0, t_now);
    add_sample(1'b0, t_now + 1);
    add_sample(1'b1, t_now + 1);
    add_sample(1'b1, t_now + 1);
    random_phase(150);
    drain();

    set_config('1, '1, '1);
    random_phase(150);
    drain();

    set_config(CFG_W'($urandom_range(0, 100)), CFG_W'($urandom_range(0, 1000)),
               CFG_W'($urandom_range(0, 2000)));
    t_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    random_phase(150);
    drain();

    idle_pct = 0;
    set_config(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 1500)),
               CFG_W'($urandom_range(0, 3000)));
    random_phase(300);
    drain();
    idle_pct = 38;

    for (int k = 0; k < 3; k++) begin
      set_config(CFG_W'($urandom), CFG_W'($urandom_range(0, 3000)),
                 CFG_W'($urandom_range(0, 5000)));
      if (k == 0) set_config(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom), CFG_W'($urandom));
      random_phase(120);
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && click_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
